### hw/rtl/rc4_stream_cipher_defines.svh
// assertion macros shared by the rc4 rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rc4_pkg.sv
// rc4 package: byte widths, s-box geometry, channel mode codes and controller states
// no dependencies
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = 8;

  localparam logic [SBOX_AW-1:0] SBOX_LAST = SBOX_AW'(SBOX_DEPTH - 1);

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [SBOX_AW-1:0] sbox_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_SUM,
    ST_KS_WRN,
    ST_KS_WRJ,
    ST_DT_RDJ,
    ST_DT_WRI,
    ST_DT_WRJ,
    ST_DT_KS,
    ST_EMIT
  } rc4_state_t;

endpackage

### hw/rtl/rc4_if.sv
// rc4 channel interfaces: input beat (mode, byte, last) and result beat
// depends on rc4_pkg for the byte width
interface rc4_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [rc4_pkg::BYTE_W-1:0] byte_value;
  logic                      last;

  modport source (output valid, output mode, output byte_value, output last, input ready);
  modport sink   (input valid, input mode, input byte_value, input last, output ready);
endinterface

interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BYTE_W-1:0] data_out;
  logic                      last_out;
  logic                      not_keyed;

  modport source (output valid, output data_out, output last_out, output not_keyed,
                  input ready);
  modport sink   (input valid, input data_out, input last_out, input not_keyed,
                  output ready);
endinterface

### hw/rtl/rc4_stream_cipher.sv
// rc4 stream cipher top level: controller, key store ram and s-box ram
// depends on rc4_pkg, rc4_if, rc4_ram and rc4_stream_cipher_defines.svh
//
// usage
//   in_ch  : valid/ready beats of {mode, byte_value, last}. mode key stores a key
//            byte (bytes past KEY_BYTES_MAX are dropped); a key beat with last set
//            runs the key schedule. mode data encrypts/decrypts one byte.
//   out_ch : one beat per data byte {data_out, last_out, not_keyed}; key beats
//            give no result. Before any schedule data passes unchanged with
//            not_keyed set.
//   timing : a key beat that is not last only stores its byte. The last key beat
//            runs an identity fill of the s-box, then one round per entry in the
//            states ks_rd, ks_sum, ks_wrn and ks_wrj, set by the single read and
//            single write port of the s-box ram. A keyed data beat passes dt_rdj,
//            dt_wri, dt_wrj, dt_ks and emit on its way to the output register; an
//            unkeyed one goes straight to emit. A new beat is taken only in idle.
//   stall  : the output register holds its beat until taken; the block keeps
//            working and may accept the next input beat meanwhile, and waits
//            only when a new result is ready and the register is still full.
//   reset  : clears the key count, i, j, the keyed flag and the output valid;
//            ram contents are left as they are and are not needed before written.
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher #(
  parameter int KEY_BYTES_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  rc4_in_if.sink     in_ch,
  rc4_out_if.source  out_ch
);

  import rc4_pkg::*;

  localparam int KAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int KCW = $clog2(KEY_BYTES_MAX + 1);

  rc4_state_t state_r, state_nxt;

  logic [KCW-1:0] key_count_r, key_count_nxt;
  logic [KCW-1:0] len_r, len_nxt;
  logic [KAW-1:0] kidx_r, kidx_nxt;
  sbox_addr_t     n_r, n_nxt;
  sbox_addr_t     i_r, i_nxt;
  sbox_addr_t     j_r, j_nxt;
  byte_t          si_r, si_nxt;
  byte_t          sj_r, sj_nxt;
  logic           fwd_r, fwd_nxt;
  logic           keyed_r, keyed_nxt;
  byte_t          data_r, data_nxt;
  logic           last_r, last_nxt;
  logic           nk_r, nk_nxt;
  logic           out_valid_r, out_valid_nxt;
  byte_t          out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_nk_r, out_nk_nxt;

  logic           s_we;
  sbox_addr_t     s_waddr;
  byte_t          s_wdata;
  sbox_addr_t     s_raddr;
  byte_t          s_rdata;
  logic           k_we;
  logic [KAW-1:0] k_waddr;
  byte_t          k_rdata;

  logic           in_acc;
  logic           out_free;
  logic [KCW-1:0] count_inc;
  logic [KCW-1:0] count_after;
  logic [KCW-1:0] kidx_inc;
  sbox_addr_t     ks_sum;
  sbox_addr_t     dt_j;
  sbox_addr_t     dt_t;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.last_out  = out_last_r;
  assign out_ch.not_keyed = out_nk_r;

  assign count_inc   = key_count_r + KCW'(1);
  assign count_after = (key_count_r < KCW'(KEY_BYTES_MAX)) ? count_inc : key_count_r;
  assign kidx_inc    = KCW'(kidx_r) + KCW'(1);
  assign ks_sum      = j_r + s_rdata + k_rdata;
  assign dt_j        = j_r + s_rdata;
  assign dt_t        = si_r + sj_r;

  assign k_we    = in_acc && (in_ch.mode == MODE_KEY) &&
                   (key_count_r < KCW'(KEY_BYTES_MAX));
  assign k_waddr = key_count_r[KAW-1:0];

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_BYTES_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_ch.byte_value),
    .raddr (kidx_r),
    .rdata (k_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_KEY) begin
            state_nxt = in_ch.last ? ST_FILL : ST_IDLE;
          end else begin
            state_nxt = keyed_r ? ST_DT_RDJ : ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        if (n_r == SBOX_LAST) begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_KS_RD:  state_nxt = ST_KS_SUM;
      ST_KS_SUM: state_nxt = ST_KS_WRN;
      ST_KS_WRN: state_nxt = ST_KS_WRJ;
      ST_KS_WRJ: state_nxt = (n_r == SBOX_LAST) ? ST_IDLE : ST_KS_RD;
      ST_DT_RDJ: state_nxt = ST_DT_WRI;
      ST_DT_WRI: state_nxt = ST_DT_WRJ;
      ST_DT_WRJ: state_nxt = ST_DT_KS;
      ST_DT_KS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    key_count_nxt = key_count_r;
    len_nxt       = len_r;
    kidx_nxt      = kidx_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    fwd_nxt       = fwd_r;
    keyed_nxt     = keyed_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    nk_nxt        = nk_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_nk_nxt    = out_nk_r;
    s_we          = 1'b0;
    s_waddr       = n_r;
    s_wdata       = n_r;
    s_raddr       = i_r + sbox_addr_t'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt = in_ch.byte_value;
          last_nxt = in_ch.last;
          if (in_ch.mode == MODE_KEY) begin
            key_count_nxt = count_after;
            if (in_ch.last) begin
              len_nxt  = count_after;
              n_nxt    = '0;
              kidx_nxt = '0;
              j_nxt    = '0;
            end
          end else begin
            nk_nxt = !keyed_r;
            if (keyed_r) begin
              i_nxt = i_r + sbox_addr_t'(1);
            end
          end
        end
      end
      ST_FILL: begin
        s_we    = 1'b1;
        s_waddr = n_r;
        s_wdata = n_r;
        n_nxt   = n_r + sbox_addr_t'(1);
      end
      ST_KS_RD: begin
        s_raddr = n_r;
      end
      ST_KS_SUM: begin
        si_nxt  = s_rdata;
        j_nxt   = ks_sum;
        s_raddr = ks_sum;
      end
      ST_KS_WRN: begin
        s_we    = 1'b1;
        s_waddr = n_r;
        s_wdata = s_rdata;
      end
      ST_KS_WRJ: begin
        s_we     = 1'b1;
        s_waddr  = j_r;
        s_wdata  = si_r;
        n_nxt    = n_r + sbox_addr_t'(1);
        kidx_nxt = (kidx_inc == len_r) ? '0 : kidx_inc[KAW-1:0];
        if (n_r == SBOX_LAST) begin
          i_nxt         = '0;
          j_nxt         = '0;
          keyed_nxt     = 1'b1;
          key_count_nxt = '0;
        end
      end
      ST_DT_RDJ: begin
        si_nxt  = s_rdata;
        j_nxt   = dt_j;
        s_raddr = dt_j;
      end
      ST_DT_WRI: begin
        s_we    = 1'b1;
        s_waddr = i_r;
        s_wdata = s_rdata;
        sj_nxt  = s_rdata;
      end
      ST_DT_WRJ: begin
        s_we    = 1'b1;
        s_waddr = j_r;
        s_wdata = si_r;
        s_raddr = dt_t;
        // s[j] is written this cycle, so its new value is taken from si_r
        fwd_nxt = (dt_t == j_r);
      end
      ST_DT_KS: begin
        data_nxt = data_r ^ (fwd_r ? si_r : s_rdata);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_last_nxt  = last_r;
          out_nk_nxt    = nk_r;
        end
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_count_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    kidx_r     <= kidx_nxt;
    n_r        <= n_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    fwd_r      <= fwd_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    nk_r       <= nk_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_nk_r   <= out_nk_nxt;
  end

  `RC4_ASSERT_NOW(a_key_count_max, 1'b1,
                  key_count_r <= KCW'(KEY_BYTES_MAX), "key count overflow")
  `RC4_ASSERT_NOW(a_data_needs_key, state_r == ST_DT_RDJ,
                  keyed_r, "keystream step while unkeyed")
  `RC4_ASSERT_NOW(a_kidx_in_key, state_r == ST_KS_RD,
                  KCW'(kidx_r) < len_r, "key index past key")
  `RC4_ASSERT_NEXT(a_sched_done, (state_r == ST_KS_WRJ) && (n_r == SBOX_LAST),
                   keyed_r && (i_r == '0) && (j_r == '0) && (key_count_r == '0) &&
                   (state_r == ST_IDLE), "schedule end state wrong")
  `RC4_ASSERT_NEXT(a_beat_from_emit, !out_valid_r,
                   !out_valid_r || $past(state_r == ST_EMIT), "result beat outside emit")

endmodule

### hw/rtl/rc4_ram.sv
// generic single-write, single-read ram with registered read data
// read during write to the same address returns the old contents; no dependencies
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/rc4_stream_cipher_test.sv
// rc4_stream_cipher testbench: directed table then randomized key/message traffic, every
// result beat checked against a typed row or an in-bench rc4 predictor under varying stalls
// depends on rc4_pkg, rc4_stream_cipher and the rc4_in_if / rc4_out_if interfaces
module rc4_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam int KEY_MAX = 256;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  not_keyed;
  } cipher_beat_t;

  typedef struct packed {
    logic  mode;
    byte_t value;
    logic  last;
    bit    typed;
    byte_t data;
    logic  last_out;
    logic  nk;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rc4_in_if  in_ch();
  rc4_out_if out_ch();

  rc4_stream_cipher #(.KEY_BYTES_MAX(KEY_MAX)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  byte_t       sbox_m [SBOX_DEPTH];
  byte_t       key_mem [KEY_MAX];
  int unsigned key_fill;
  byte_t       ptr_i;
  byte_t       ptr_j;
  bit          is_keyed;

  cipher_beat_t expected_bytes [$];
  bit           use_typed;
  cipher_beat_t typed_result;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned results_checked;
  int unsigned schedules_seen;
  int unsigned key_beats_taken;

  stim_row_t directed_rows [22];

  function automatic void schedule_key();
    int unsigned span;
    byte_t acc;
    byte_t t;
    span = (key_fill == 0) ? 1 : key_fill;
    for (int n = 0; n < SBOX_DEPTH; n++) sbox_m[n] = byte_t'(n);
    acc = '0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      acc = acc + sbox_m[n] + key_mem[n % span];
      t = sbox_m[n];
      sbox_m[n] = sbox_m[acc];
      sbox_m[acc] = t;
    end
    ptr_i = '0;
    ptr_j = '0;
    is_keyed = 1'b1;
    key_fill = 0;
    schedules_seen++;
  endfunction

  function automatic byte_t keystream_byte();
    byte_t t;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox_m[ptr_i];
    t = sbox_m[ptr_i];
    sbox_m[ptr_i] = sbox_m[ptr_j];
    sbox_m[ptr_j] = t;
    return sbox_m[byte_t'(sbox_m[ptr_i] + sbox_m[ptr_j])];
  endfunction

  function automatic bit apply_cipher_beat(logic mode, byte_t value, logic last,
                                           output cipher_beat_t res);
    res = '0;
    if (mode == MODE_KEY) begin
      if (key_fill < KEY_MAX) begin
        key_mem[key_fill] = value;
        key_fill++;
      end
      if (last) schedule_key();
      return 1'b0;
    end
    if (!is_keyed) begin
      res = '{value, last, 1'b1};
    end else begin
      res = '{value ^ keystream_byte(), last, 1'b0};
    end
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("rc4_stream_cipher_test failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    cipher_beat_t got;
    cipher_beat_t want;
    cipher_beat_t model;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.data_out, out_ch.last_out, out_ch.not_keyed};
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected beat data %02h last %0b not_keyed %0b",
                   $time, got.data, got.last, got.not_keyed);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data || got.last !== want.last ||
              got.not_keyed !== want.not_keyed) begin
            $display("%0t: mismatch expected data %02h last %0b not_keyed %0b, got data %02h last %0b not_keyed %0b",
                     $time, want.data, want.last, want.not_keyed,
                     got.data, got.last, got.not_keyed);
            errors++;
          end
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_KEY) key_beats_taken++;
        if (apply_cipher_beat(in_ch.mode, in_ch.byte_value, in_ch.last, model))
          expected_bytes.push_back(use_typed ? typed_result : model);
      end
    end
  end

  task automatic send_beat(logic mode, byte_t value, logic last, bit typed,
                           cipher_beat_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.byte_value <= value;
    in_ch.last       <= last;
    use_typed        <= typed;
    typed_result     <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_byte(logic mode, byte_t value, logic last);
    send_beat(mode, value, last, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned quota,
                           bit force_long);
    int unsigned count;
    int unsigned len;
    int unsigned nmsg;
    int unsigned r;
    bit first;
    count = 0;
    first = 1'b1;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (count < quota) begin
      r = $urandom_range(99);
      if (r < 85 || first) begin
        if ((first && force_long) || $urandom_range(29) == 0)
          len = $urandom_range(250, 320);
        else
          len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
          put_byte(MODE_KEY, byte_t'($urandom), k == len - 1);
        count += (len < KEY_MAX) ? len : KEY_MAX;
        nmsg = $urandom_range(1, 3);
        for (int m = 0; m < nmsg; m++) begin
          len = $urandom_range(1, 40);
          for (int k = 0; k < len; k++)
            put_byte(MODE_DATA, byte_t'($urandom), k == len - 1);
          count += len;
        end
      end else if (r < 93) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          put_byte(MODE_DATA, byte_t'($urandom), logic'($urandom_range(1)));
        count += len;
      end else begin
        // stray key bytes, they lead the next key
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          put_byte(MODE_KEY, byte_t'($urandom), 1'b0);
        count += len;
      end
      first = 1'b0;
    end
    drain_results();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_KEY;
    in_ch.byte_value = '0;
    in_ch.last       = 1'b0;
    use_typed        = 1'b0;
    typed_result     = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    errors           = 0;
    results_checked  = 0;
    schedules_seen   = 0;
    key_beats_taken  = 0;
    key_fill         = 0;
    ptr_i            = '0;
    ptr_j            = '0;
    is_keyed         = 1'b0;
    foreach (sbox_m[n]) sbox_m[n] = '0;
    foreach (key_mem[n]) key_mem[n] = '0;

    directed_rows = '{
      // unkeyed passthrough
      '{MODE_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1},
      '{MODE_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1},
      '{MODE_DATA, 8'h5A, 1'b0, 1'b1, 8'h5A, 1'b0, 1'b1},
      // key "Key", message "Plaintext"
      '{MODE_KEY,  8'h4B, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_KEY,  8'h65, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_KEY,  8'h79, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h6C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h61, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h69, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h6E, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h74, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h65, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h74, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      // single zero key byte
      '{MODE_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      // key bytes while keyed leave the stream running
      '{MODE_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_KEY,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{MODE_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[n])
      send_beat(directed_rows[n].mode, directed_rows[n].value, directed_rows[n].last,
                directed_rows[n].typed,
                '{directed_rows[n].data, directed_rows[n].last_out, directed_rows[n].nk});
    drain_results();

    run_phase(0, 0, 440, 1'b0);
    run_phase(70, 0, 440, 1'b1);
    run_phase(0, 70, 440, 1'b0);
    run_phase(38, 38, 440, 1'b0);

    repeat (1300) @(posedge clk);

    $display("checked %0d result beats over %0d key schedules (%0d key beats taken)",
             results_checked, schedules_seen, key_beats_taken);
    $display("handshake phases: free running, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("rc4_stream_cipher_test passed");
    end else begin
      $display("rc4_stream_cipher_test failed");
    end
    $finish;
  end
endmodule

### rc4_stream_cipher.f
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_if.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_test.sv
